### rtl/core/krmv_pkg.sv
`timescale 1ns / 1ps
package krmv_pkg;

    localparam int MaxLogSize = 8;
    localparam int ValueWidth = 32;
    localparam int FracBits   = 22;
    localparam int IdxWidth   = MaxLogSize;
    localparam int FiWidth    = $clog2(MaxLogSize);
    localparam int BufDepth   = 1 << (MaxLogSize - 1);
    localparam int BufAw      = MaxLogSize - 1;
    localparam int QDepth     = 2;

    localparam logic signed [ValueWidth-1:0] VMax = {1'b0, {(ValueWidth-1){1'b1}}};
    localparam logic signed [ValueWidth-1:0] VMin = {1'b1, {(ValueWidth-1){1'b0}}};

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_ELEM = 1'b1;

    typedef enum logic [1:0] {
        CFG_ROW  = 2'd0,
        CFG_DIAG = 2'd1,
        CFG_TRN  = 2'd2,
        CFG_LOG  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic                         op;
        logic [2:0]                   factor_index;
        logic signed [ValueWidth-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]                   result_index;
        logic signed [ValueWidth-1:0] result_value;
        logic                         last;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic                         two;      // emits a pair
        logic                         zero_lo;  // lower result forced zero
        logic                         zero_hi;  // upper result forced zero
        logic                         neg_lo;   // lower result is negated product
        logic                         last;
        logic [IdxWidth-1:0]          k;
        logic [IdxWidth-1:0]          lowk;
        logic [MaxLogSize-1:0]        mask;     // factors still to multiply in
        logic signed [ValueWidth-1:0] start;    // operand for the first product
        logic                         use_f;    // first multiply is by row factor
    } job_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_WAIT,
        B_OUT0,
        B_OUT1
    } bstate_t;

    function automatic logic signed [ValueWidth-1:0] qmul(
        input logic signed [ValueWidth-1:0] a,
        input logic signed [ValueWidth-1:0] b
    );
        logic signed [2*ValueWidth-1:0] p;
        logic        [2*ValueWidth-1:0] mag;
        logic        [2*ValueWidth-1:0] r;
        logic                           neg;
        p   = a * b;
        neg = p[2*ValueWidth-1];
        mag = neg ? (~p + 1'b1) : p;
        r   = (mag + (64'(1) << (FracBits - 1))) >> FracBits;
        if (neg) begin
            if (r >= {1'b0, VMax} + 1'b1) qmul = VMin;
            else qmul = ValueWidth'(-r);
        end else begin
            if (r > {1'b0, VMax}) qmul = VMax;
            else qmul = ValueWidth'(r);
        end
    endfunction

endpackage

### rtl/core/krmv_ram.sv
`timescale 1ns / 1ps
module krmv_ram #(
    parameter int Width = 32,
    parameter int Depth = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/krmv_front.sv
`timescale 1ns / 1ps
module krmv_front (
    input  logic                clk,
    input  logic                rst_n,
    input  krmv_pkg::in_item_t  req,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic                cfg_wr,
    input  logic [2:0]          row_select,
    input  logic                use_diagonal,
    input  logic                transposed,
    input  logic [3:0]          log_size,
    output logic                load_we,
    output logic [2:0]          load_idx,
    output logic signed [krmv_pkg::ValueWidth-1:0] load_val,
    input  logic                back_busy,
    output krmv_pkg::job_t      job,
    output logic                job_valid,
    input  logic                job_pop
);
    localparam int VW = krmv_pkg::ValueWidth;
    localparam int IW = krmv_pkg::IdxWidth;

    // stage 1: accept, write/read partner buffer; stage 2: build job into queue
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          s1_valid_reg;
    logic          s1_pair_reg;
    logic          s1_last_reg;
    logic [IW-1:0] s1_k_reg, s1_lowk_reg, s1_mask_reg, s1_slot_reg;
    logic signed [VW-1:0] s1_x_reg;
    logic [1:0]    q_cnt_reg;
    krmv_pkg::job_t q_reg [krmv_pkg::QDepth];
    logic [VW-1:0] partner;

    logic [3:0]    n;
    logic [IW:0]   len_m1;
    logic [IW-1:0] k;
    logic          lst, pair_mode, upper, accept, elem;
    logic [IW-1:0] bmask, lowk, slot, fmask, rd_slot;
    logic signed [VW-1:0] diff;
    logic signed [VW:0]   dwide;
    krmv_pkg::job_t newjob;
    logic          push;
    logic          in_flight;

    assign n      = (log_size > 4'(krmv_pkg::MaxLogSize)) ? 4'(krmv_pkg::MaxLogSize) : log_size;
    assign len_m1 = (IW+1)'((1 << n) - 1);
    assign k      = cnt_reg & len_m1[IW-1:0];
    assign lst    = ({1'b0, k} == len_m1);
    assign pair_mode = ({1'b0, row_select} < n);
    assign bmask  = IW'(1) << row_select;
    assign upper  = |(k & bmask);
    assign lowk   = k & ~bmask;
    assign slot   = (lowk & (bmask - 1'b1)) |
                    ((lowk >> ({1'b0, row_select} + 4'd1)) << row_select);
    assign fmask  = IW'(len_m1[IW-1:0] & (pair_mode ? ~bmask : {IW{1'b1}}));

    // a factor load waits until no element is left that still needs the old factors
    assign in_flight = s1_valid_reg || (q_cnt_reg != 2'd0) || back_busy;

    // hold input while the queue can't take a stage-1 item, or hold a factor load while elements are in flight
    assign req_stall = (s1_valid_reg && (q_cnt_reg == 2'(krmv_pkg::QDepth)) && !job_pop) ||
                       ((req.op == krmv_pkg::OP_LOAD) && in_flight);
    assign accept = req_valid && !req_stall;
    assign elem   = accept && (req.op == krmv_pkg::OP_ELEM);

    assign load_we  = accept && (req.op == krmv_pkg::OP_LOAD);
    assign load_idx = req.factor_index;
    assign load_val = req.value;

    // a held stage-1 item keeps re-reading its own partner
    assign rd_slot = (!s1_valid_reg || push) ? slot : s1_slot_reg;

    krmv_ram #(.Width(VW), .Depth(krmv_pkg::BufDepth)) u_buf (
        .clk   (clk),
        .we    (elem && pair_mode && !upper),
        .waddr (slot[krmv_pkg::BufAw-1:0]),
        .wdata (req.value),
        .raddr (rd_slot[krmv_pkg::BufAw-1:0]),
        .rdata (partner)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cfg_wr) cnt_next = '0;
        else if (elem) cnt_next = lst ? '0 : k + 1'b1;
    end

    always_comb
    begin
        dwide = {s1_x_reg[VW-1], s1_x_reg} - {partner[VW-1], partner};
        if (dwide > (VW+1)'(krmv_pkg::VMax)) diff = krmv_pkg::VMax;
        else if (dwide < (VW+1)'(krmv_pkg::VMin)) diff = krmv_pkg::VMin;
        else diff = dwide[VW-1:0];
        newjob         = '0;
        newjob.two     = s1_pair_reg;
        newjob.last    = s1_last_reg;
        newjob.k       = s1_k_reg;
        newjob.lowk    = s1_lowk_reg;
        newjob.mask    = s1_mask_reg & s1_k_reg;
        newjob.use_f   = s1_pair_reg;
        newjob.zero_hi = s1_pair_reg && transposed;
        newjob.zero_lo = s1_pair_reg && !transposed && !use_diagonal;
        newjob.neg_lo  = s1_pair_reg && !transposed && use_diagonal;
        if (!s1_pair_reg) newjob.start = s1_x_reg;
        else if (!transposed) newjob.start = signed'(partner);
        else newjob.start = use_diagonal ? diff : s1_x_reg;
    end

    assign push      = s1_valid_reg && (q_cnt_reg != 2'(krmv_pkg::QDepth) || job_pop);
    assign job       = q_reg[0];
    assign job_valid = (q_cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            s1_valid_reg <= 1'b0;
            q_cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push || !s1_valid_reg)
            begin
                s1_valid_reg <= elem && (!pair_mode || upper);
            end
            q_cnt_reg <= q_cnt_reg + 2'(push) - 2'(job_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_valid_reg || push)
        begin
            s1_pair_reg <= pair_mode;
            s1_last_reg <= lst;
            s1_k_reg    <= k;
            s1_lowk_reg <= pair_mode ? lowk : k;
            s1_mask_reg <= fmask;
            s1_slot_reg <= slot;
            s1_x_reg    <= req.value;
        end
        if (job_pop)
        begin
            q_reg[0] <= (q_cnt_reg == 2'd2) ? q_reg[1] : newjob;
            if (q_cnt_reg == 2'd2) q_reg[1] <= newjob;
        end
        else if (push)
        begin
            if (q_cnt_reg == 2'd0) q_reg[0] <= newjob;
            else q_reg[1] <= newjob;
        end
    end
endmodule

### rtl/core/krmv_back.sv
`timescale 1ns / 1ps
module krmv_back (
    input  logic                clk,
    input  logic                rst_n,
    input  krmv_pkg::job_t      job,
    input  logic                job_valid,
    output logic                job_pop,
    output logic                busy,
    input  logic [2:0]          row_select,
    input  logic                load_we,
    input  logic [2:0]          load_idx,
    input  logic signed [krmv_pkg::ValueWidth-1:0] load_val,
    output krmv_pkg::out_item_t result,
    output logic                result_valid,
    input  logic                result_stall
);
    localparam int VW = krmv_pkg::ValueWidth;
    localparam int MW = krmv_pkg::MaxLogSize;

    logic signed [VW-1:0] factors_reg [MW];
    krmv_pkg::bstate_t state_reg, state_next;
    krmv_pkg::job_t    cur_reg;
    logic signed [VW-1:0] acc_reg;
    logic signed [VW-1:0] prod_reg;
    logic [MW-1:0]     mask_reg;
    logic              first_reg;
    logic [$clog2(MW)-1:0] pick;
    logic signed [VW-1:0]  opnd, negv;
    logic              out_take;
    krmv_pkg::out_item_t out_reg;
    logic              out_valid_reg;

    // lowest pending factor bit
    always_comb
    begin
        pick = '0;
        for (int j = MW - 1; j >= 0; j--)
        begin
            if (mask_reg[j]) pick = ($clog2(MW))'(j);
        end
    end

    assign opnd     = first_reg ? factors_reg[row_select] : factors_reg[pick];
    assign out_take = !out_valid_reg || !result_stall;
    assign negv     = (acc_reg == krmv_pkg::VMin) ? krmv_pkg::VMax : -acc_reg;
    assign job_pop  = (state_reg == krmv_pkg::B_IDLE) && job_valid;
    assign busy     = (state_reg == krmv_pkg::B_MUL) || (state_reg == krmv_pkg::B_WAIT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            krmv_pkg::B_IDLE: if (job_valid) state_next = krmv_pkg::B_MUL;
            krmv_pkg::B_MUL:
                if (!first_reg && mask_reg == '0) state_next = krmv_pkg::B_WAIT;
                else state_next = krmv_pkg::B_WAIT;
            krmv_pkg::B_WAIT:
                if (!first_reg && mask_reg == '0)
                    state_next = cur_reg.two ? krmv_pkg::B_OUT0 : krmv_pkg::B_OUT1;
                else state_next = krmv_pkg::B_MUL;
            krmv_pkg::B_OUT0: if (out_take) state_next = krmv_pkg::B_OUT1;
            krmv_pkg::B_OUT1: if (out_take) state_next = krmv_pkg::B_IDLE;
            default: state_next = krmv_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= krmv_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_take)
            begin
                out_valid_reg <= (state_reg == krmv_pkg::B_OUT0) ||
                                 (state_reg == krmv_pkg::B_OUT1);
            end
        end
    end

    // B_MUL registers the product, B_WAIT folds it into the accumulator
    always_ff @(posedge clk)
    begin
        if (load_we) factors_reg[load_idx] <= load_val;
        unique case (state_reg)
            krmv_pkg::B_IDLE:
            begin
                cur_reg   <= job;
                acc_reg   <= job.start;
                mask_reg  <= job.mask;
                first_reg <= job.use_f;
            end
            krmv_pkg::B_MUL:
            begin
                if (first_reg || mask_reg != '0) prod_reg <= krmv_pkg::qmul(acc_reg, opnd);
                else prod_reg <= acc_reg;
            end
            krmv_pkg::B_WAIT:
            begin
                acc_reg <= prod_reg;
                if (first_reg) first_reg <= 1'b0;
                else if (mask_reg != '0) mask_reg[pick] <= 1'b0;
            end
            default: ;
        endcase
        if (out_take)
        begin
            if (state_reg == krmv_pkg::B_OUT0)
            begin
                out_reg.result_index <= 8'(cur_reg.lowk);
                out_reg.last         <= 1'b0;
                out_reg.result_value <= cur_reg.zero_lo ? '0 : (cur_reg.neg_lo ? negv : acc_reg);
            end
            else
            begin
                out_reg.result_index <= 8'(cur_reg.k);
                out_reg.last         <= cur_reg.last;
                out_reg.result_value <= cur_reg.zero_hi ? '0 : acc_reg;
            end
        end
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;
endmodule

### rtl/core/kronecker_rate_matrix_vector_product.sv
`timescale 1ns / 1ps
// Streams a 2^n vector through one Kronecker rate factor. Factor loads (op 0)
// and elements (op 1) share the input channel; a config write restarts the
// vector. The front end pairs elements through a partner buffer and queues
// jobs; the back end runs one shared Q10.22 multiplier, a B_MUL and a B_WAIT
// step per factor, and pops a new job only after the last one's results.
// Lower pair elements make no job; their result leaves with the upper one's. A
// factor load is stalled until every element ahead has left the multiplier.
module kronecker_rate_matrix_vector_product (
    input  logic                clk,
    input  logic                rst_n,
    input  krmv_pkg::in_item_t  in_data,
    input  logic                in_valid,
    output logic                in_stall,
    output krmv_pkg::out_item_t out_data,
    output logic                out_valid,
    input  logic                out_stall,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [3:0]          cfg_data
);
    logic [2:0] row_select_reg;
    logic       use_diagonal_reg, transposed_reg;
    logic [3:0] log_size_reg;
    logic       cfg_wr;
    logic       load_we, job_valid, job_pop, back_busy;
    logic [2:0] load_idx;
    logic signed [krmv_pkg::ValueWidth-1:0] load_val;
    krmv_pkg::job_t job;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_select_reg   <= '0;
            use_diagonal_reg <= 1'b0;
            transposed_reg   <= 1'b0;
            log_size_reg     <= 4'd8;
        end
        else if (cfg_wr)
        begin
            unique case (krmv_pkg::cfg_idx_t'(cfg_index))
                krmv_pkg::CFG_ROW:  row_select_reg   <= cfg_data[2:0];
                krmv_pkg::CFG_DIAG: use_diagonal_reg <= cfg_data[0];
                krmv_pkg::CFG_TRN:  transposed_reg   <= cfg_data[0];
                krmv_pkg::CFG_LOG:  log_size_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    krmv_front u_front (
        .clk(clk), .rst_n(rst_n), .req(in_data), .req_valid(in_valid),
        .req_stall(in_stall), .cfg_wr(cfg_wr), .row_select(row_select_reg),
        .use_diagonal(use_diagonal_reg), .transposed(transposed_reg),
        .log_size(log_size_reg), .load_we(load_we), .load_idx(load_idx),
        .load_val(load_val), .back_busy(back_busy), .job(job),
        .job_valid(job_valid), .job_pop(job_pop)
    );

    krmv_back u_back (
        .clk(clk), .rst_n(rst_n), .job(job), .job_valid(job_valid),
        .job_pop(job_pop), .busy(back_busy), .row_select(row_select_reg),
        .load_we(load_we), .load_idx(load_idx), .load_val(load_val),
        .result(out_data), .result_valid(out_valid), .result_stall(out_stall)
    );

    a_last_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last |-> out_data.result_index ==
            8'((1 << ((log_size_reg > 4'd8) ? 4'd8 : log_size_reg)) - 1))
        else $error("last flag on wrong index");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_valid)
        else $error("job popped from empty queue");
endmodule
